// ----- hdl/static_arp_table_unit_macros.svh -----
// Assertion macros used by the static ARP table sequencer (satu_ctrl).
// No dependencies; the using module must have signals clk and rst.
`ifndef STATIC_ARP_TABLE_UNIT_MACROS_SVH
`define STATIC_ARP_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SATU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SATU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/satu_pkg.sv -----
// Shared types and constants for the static ARP table unit.
// No dependencies.
`default_nettype none

package satu_pkg;

  localparam int CMD_W    = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = IP_W + MAC_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_WALK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_ENTRY   = 3'd4
  } status_t;

  typedef struct packed {
    logic             strobe;
    status_t          status;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/satu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module satu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/satu_flags.sv -----
// Valid marks of the table slots, one flip-flop per slot, cleared on reset.
// No dependencies.
`default_nettype none

module satu_flags #(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             set_en,
  input  wire logic             clr_en,
  input  wire logic [IDX_W-1:0] idx,
  output logic      [DEPTH-1:0] flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      if (set_en) begin
        flags[idx] <= 1'b1;
      end
      if (clr_en) begin
        flags[idx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/satu_ctrl.sv -----
// Command sequencer: sweeps the entry RAM, compares, and issues results.
// Depends on satu_pkg and static_arp_table_unit_macros.svh.
`default_nettype none
`include "static_arp_table_unit_macros.svh"

module satu_ctrl
  import satu_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [CMD_W-1:0]       cmd,
  input  wire logic [IP_W-1:0]        ip_addr,
  input  wire logic [MAC_W-1:0]       mac_addr,
  input  wire logic [IP_W-1:0]        net_mask,
  input  wire logic [TABLE_DEPTH-1:0] flags,
  output logic                        flag_set,
  output logic                        flag_clr,
  output logic      [IDX_W-1:0]       flag_idx,
  output logic                        ram_re,
  output logic      [IDX_W-1:0]       ram_raddr,
  input  wire logic [ENTRY_W-1:0]     ram_rdata,
  output logic                        ram_we,
  output logic      [IDX_W-1:0]       ram_waddr,
  output logic      [ENTRY_W-1:0]     ram_wdata,
  output res_t                        res
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] rd_cnt;
  logic             p1_vld;
  logic             p1_end;
  logic [IDX_W-1:0] p1_idx;
  cmd_t             cmd_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [IP_W-1:0]  mask_q;
  logic             found, found_next;
  logic [IDX_W-1:0] match_idx, match_idx_next;
  logic             free_found, free_found_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic             accept;
  logic             hit_v;
  logic [IP_W-1:0]  hit_ip;
  logic [MAC_W-1:0] hit_mac;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign ram_re    = (state == S_SCAN) && (rd_cnt < CNT_W'(TABLE_DEPTH));
  assign ram_raddr = rd_cnt[IDX_W-1:0];
  assign ram_waddr = free_idx;
  assign ram_wdata = {ip_q, mac_q};
  assign hit_ip    = ram_rdata[ENTRY_W-1:MAC_W];
  assign hit_mac   = ram_rdata[MAC_W-1:0];
  assign hit_v     = flags[p1_idx];

  always_comb begin
    state_next      = state;
    found_next      = found;
    match_idx_next  = match_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    flag_set        = 1'b0;
    flag_clr        = 1'b0;
    flag_idx        = p1_idx;
    ram_we          = 1'b0;
    res             = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (p1_vld) begin
          case (cmd_q)
            CMD_ADD: begin
              if (hit_v && (hit_ip == ip_q)) begin
                found_next = 1'b1;
              end
              if (!hit_v && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = p1_idx;
              end
            end
            CMD_DELETE: begin
              if (hit_v && (hit_ip == ip_q) && !found) begin
                found_next     = 1'b1;
                match_idx_next = p1_idx;
              end
            end
            CMD_CLEAR: begin
              if (hit_v) begin
                res.strobe = 1'b1;
                res.status = ST_ENTRY;
                res.ip     = hit_ip;
                res.mac    = hit_mac;
                flag_clr   = 1'b1;
              end
            end
            CMD_WALK: begin
              if (hit_v && (((hit_ip ^ ip_q) & mask_q) == '0)) begin
                res.strobe = 1'b1;
                res.status = ST_ENTRY;
                res.ip     = hit_ip;
                res.mac    = hit_mac;
              end
            end
            default: begin
            end
          endcase
          if (p1_end) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        res.strobe = 1'b1;
        res.last   = 1'b1;
        res.status = ST_OK;
        case (cmd_q)
          CMD_ADD: begin
            flag_idx = free_idx;
            if (found) begin
              res.status = ST_PRESENT;
            end else if (!free_found) begin
              res.status = ST_FULL;
            end else begin
              ram_we   = 1'b1;
              flag_set = 1'b1;
            end
          end
          CMD_DELETE: begin
            flag_idx = match_idx;
            if (found) begin
              flag_clr = 1'b1;
            end else begin
              res.status = ST_ABSENT;
            end
          end
          default: begin
          end
        endcase
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_cnt     <= '0;
      p1_vld     <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state  <= state_next;
      p1_vld <= ram_re;
      if (accept) begin
        rd_cnt     <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        found      <= found_next;
        free_found <= free_found_next;
        if (ram_re) begin
          rd_cnt <= rd_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx    <= ram_raddr;
    p1_end    <= (rd_cnt == CNT_W'(TABLE_DEPTH - 1));
    match_idx <= match_idx_next;
    free_idx  <= free_idx_next;
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      ip_q   <= ip_addr;
      mac_q  <= mac_addr;
      mask_q <= net_mask;
    end
  end

  `SATU_ASSERT_IMP(a_no_res_idle, res.strobe, state != S_IDLE, "result issued while idle")
  `SATU_ASSERT_NEXT(a_finish_ends, state == S_FINISH, state == S_IDLE, "finish did not end")
  `SATU_ASSERT_IMP(a_we_no_read, ram_we, !ram_re && cmd_q == CMD_ADD, "write during sweep")
  `SATU_ASSERT_NEXT(a_start_busy, accept, busy, "accepted request did not raise busy")

endmodule

`default_nettype wire

// ----- hdl/static_arp_table_unit.sv -----
// Top level of the static ARP table unit: entry RAM, valid marks, sequencer
// and result register. Depends on satu_pkg, satu_ram, satu_flags, satu_ctrl.
`default_nettype none

// A table of TABLE_DEPTH static IPv4-to-MAC entries. A request is taken when
// start is high and busy is low; busy then stays high until the request is
// done, and no new request is taken before then. The length of a request is
// set by the sweep of the entry RAM, one slot read per cycle through its
// single read port, followed by a finish state that issues the closing result.
// Every request sweeps the whole table, whatever its command. Results come
// out on strobe, one per cycle at most, and stay on the ports for exactly one
// cycle: the receiver cannot stall, so capture each one when strobe is high.
// Entry reports of clear and walk follow in slot order, lowest first, and the
// last result of every request carries last = 1. The final result of a
// request is on the ports in the same cycle in which busy falls. Valid marks
// clear on reset at once; the IP and MAC storage needs no clearing pass.
module static_arp_table_unit
  import satu_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [IP_W-1:0]     ip_addr,
  input  wire logic [MAC_W-1:0]    mac_addr,
  input  wire logic [IP_W-1:0]     net_mask,
  output logic                     strobe,
  output logic      [STATUS_W-1:0] status,
  output logic      [IP_W-1:0]     entry_ip,
  output logic      [MAC_W-1:0]    entry_mac,
  output logic                     last
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TABLE_DEPTH-1:0] flags;
  logic                   flag_set;
  logic                   flag_clr;
  logic [IDX_W-1:0]       flag_idx;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  res_t                   res;
  res_t                   res_q;

  // IP in the upper bits, MAC in the lower bits of each word.
  satu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Valid marks live in flip-flops so that reset empties the table at once.
  satu_flags #(
    .DEPTH (TABLE_DEPTH)
  ) u_flags (
    .clk    (clk),
    .rst    (rst),
    .set_en (flag_set),
    .clr_en (flag_clr),
    .idx    (flag_idx),
    .flags  (flags)
  );

  // Sweep the RAM, compare each slot, and form each result.
  satu_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .ip_addr   (ip_addr),
    .mac_addr  (mac_addr),
    .net_mask  (net_mask),
    .flags     (flags),
    .flag_set  (flag_set),
    .flag_clr  (flag_clr),
    .flag_idx  (flag_idx),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res       (res)
  );

  // Register each result onto the ports; hold the strobe for one cycle only.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q.strobe <= 1'b0;
    end else begin
      res_q.strobe <= res.strobe;
    end
    res_q.status <= res.status;
    res_q.ip     <= res.ip;
    res_q.mac    <= res.mac;
    res_q.last   <= res.last;
  end

  assign strobe    = res_q.strobe;
  assign status    = res_q.status;
  assign entry_ip  = res_q.ip;
  assign entry_mac = res_q.mac;
  assign last      = res_q.last;

endmodule

`default_nettype wire
